// ===== design/char_lcd_nibble_sequencer_defines.svh =====
// assertion macros for the character display nibble sequencer
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCDNS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCDNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcdns_pkg.sv =====
// shared types, constants and helpers of the character display nibble sequencer
package lcdns_pkg;

  // input command codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_TEXT   = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_STROBE_HOLD   = 2'd0;
  localparam logic [1:0] REG_GAP_HOLD      = 2'd1;
  localparam logic [1:0] REG_POWER_UP_WAIT = 2'd2;
  localparam logic [1:0] REG_CLEAR_WAIT    = 2'd3;

  localparam logic [15:0] StrobeHoldReset  = 16'd80;
  localparam logic [15:0] GapHoldReset     = 16'd10;
  localparam logic [15:0] PowerUpWaitReset = 16'd30000;
  localparam logic [15:0] ClearWaitReset   = 16'd65000;

  localparam logic [7:0] EntryModeInstr = 8'h06;
  localparam logic [7:0] SetDdramBase   = 8'h80;
  localparam logic [3:0] NibbleMask     = 4'hf;

  // phase counter end points
  localparam logic [3:0] LastOnePhase  = 4'd3;
  localparam logic [3:0] LastTwoPhase  = 4'd7;
  localparam logic [3:0] LastInitPhase = 4'd13;

  // queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_ONE  = 2'd1,
    JOB_TWO  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic       rs0;
    logic [7:0] byte0;
    logic       rs1;
    logic [7:0] byte1;
  } job_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_level;
    logic [3:0]  nibble;
    logic [15:0] hold_count;
    logic        last_phase;
  } phase_t;

  typedef struct packed {
    logic [15:0] strobe_hold;
    logic [15:0] gap_hold;
    logic [15:0] power_up_wait;
    logic [15:0] clear_wait;
  } cfg_t;

  // function set, display on and clear, sent in that order by init
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h2f;
      2'd1:    b = 8'h0c;
      2'd2:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/char_lcd_nibble_sequencer.sv =====
// top level of the character display nibble sequencer
// Turns display commands into pin phases for a character display on a 4-bit
// bus. Each output item is one phase: register select (tuser), enable level,
// data nibble and hold count (tdata); tlast marks the final phase of the run
// caused by one command. Hold times are carried out by whatever consumes the
// stream. Instruction, data and cursor move give 4 phases, text character 8
// and init 14; the back end emits one phase per cycle while the consumer is
// ready, stepping through each run of phases with the back end's phase counter.
// Commands with the codes 5 to 7 are taken and produce nothing. The front end
// takes a new command every cycle while the two-entry job queue has room, so
// commands keep flowing in while earlier runs are still being sent. Output is
// registered; a stalled consumer holds the current phase. The config port is
// always ready and should only be written while the block is idle.
`include "char_lcd_nibble_sequencer_defines.svh"

module char_lcd_nibble_sequencer import lcdns_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], row[8], column[14:9], zero[15]
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  // phase stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // enable_level[0], nibble[4:1], hold_count[20:5], zero
  output logic [0:0]  m_axis_tuser,   // reg_select[0]
  output logic        m_axis_tlast,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t   cfg_q, cfg_d;
  logic   push;
  job_t   push_job;
  logic   q_full;
  logic   q_empty;
  logic   pop;
  job_t   head_job;
  phase_t out_phase;
  logic   out_valid;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STROBE_HOLD:   cfg_d.strobe_hold   = cfg_data_i;
        REG_GAP_HOLD:      cfg_d.gap_hold      = cfg_data_i;
        REG_POWER_UP_WAIT: cfg_d.power_up_wait = cfg_data_i;
        REG_CLEAR_WAIT:    cfg_d.clear_wait    = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strobe_hold   <= StrobeHoldReset;
      cfg_q.gap_hold      <= GapHoldReset;
      cfg_q.power_up_wait <= PowerUpWaitReset;
      cfg_q.clear_wait    <= ClearWaitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end takes a command whenever the queue has room
  assign s_axis_tready = !q_full;

  lcdns_front u_front (
    .in_valid_i   (s_axis_tvalid && s_axis_tready),
    .command_i    (s_axis_tuser),
    .byte_value_i (s_axis_tdata[7:0]),
    .row_i        (s_axis_tdata[8]),
    .column_i     (s_axis_tdata[14:9]),
    .push_o       (push),
    .job_o        (push_job)
  );

  lcdns_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  lcdns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_phase)
  );

  // output packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_phase.hold_count, out_phase.nibble,
                          out_phase.enable_level};
  assign m_axis_tuser  = out_phase.reg_select;
  assign m_axis_tlast  = out_phase.last_phase;

  // every run ends on a gap or wait phase, never with enable high
  `LCDNS_ASSERT_IMPL(a_last_enable_low, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0], "run ended with enable high")
  // bus is cleared whenever enable is low
  `LCDNS_ASSERT_IMPL(a_gap_bus_clear, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[4:1] == 4'd0, "nibble driven while enable low")
  // a queued job with a free output slot shows up on the output next cycle
  `LCDNS_ASSERT_NEXT(a_back_progress, !q_empty && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid, "back end stalled with work queued")

endmodule

// ===== design/lcdns_front.sv =====
// front end: classifies incoming commands into queued jobs
module lcdns_front import lcdns_pkg::*; (
  input  logic       in_valid_i,
  input  logic [2:0] command_i,
  input  logic [7:0] byte_value_i,
  input  logic       row_i,
  input  logic [5:0] column_i,
  output logic       push_o,
  output job_t       job_o
);

  logic       known;
  logic [7:0] cursor_byte;

  assign cursor_byte = SetDdramBase + {1'b0, row_i, column_i};

  always_comb begin
    known     = 1'b1;
    job_o     = '0;
    job_o.kind = JOB_ONE;
    case (command_i)
      CMD_INIT: begin
        job_o.kind = JOB_INIT;
      end
      CMD_INSTR: begin
        job_o.byte0 = byte_value_i;
      end
      CMD_DATA: begin
        job_o.rs0   = 1'b1;
        job_o.byte0 = byte_value_i;
      end
      CMD_TEXT: begin
        job_o.kind  = JOB_TWO;
        job_o.byte0 = EntryModeInstr;
        job_o.rs1   = 1'b1;
        job_o.byte1 = byte_value_i;
      end
      CMD_CURSOR: begin
        job_o.byte0 = cursor_byte;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused codes are accepted and dropped here
  assign push_o = in_valid_i && known;

endmodule

// ===== design/lcdns_queue.sv =====
// short job queue between the front end and the phase sequencer
module lcdns_queue import lcdns_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  job_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/lcdns_back.sv =====
// back end: steps through the pin phases of the head job, one per cycle unless stalled
module lcdns_back import lcdns_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   empty_i,
  input  job_t   job_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output phase_t out_o
);

  logic [3:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  phase_t     out_q;
  phase_t     cur;
  logic [3:0] step;
  logic [1:0] bidx;
  logic [1:0] sub;
  logic       is_wait;
  logic       cur_rs;
  logic [7:0] cur_byte;
  logic       advance;

  always_comb begin
    step = (job_i.kind == JOB_INIT) ? phase_q - 4'd1 : phase_q;
  end
  assign bidx = step[3:2];
  assign sub  = step[1:0];

  always_comb begin
    is_wait  = 1'b0;
    cur_rs   = 1'b0;
    cur_byte = job_i.byte0;
    cur.last_phase = 1'b0;
    case (job_i.kind)
      JOB_INIT: begin
        is_wait  = (phase_q == 4'd0) || (phase_q == LastInitPhase);
        cur_byte = init_byte(bidx);
        cur.last_phase = (phase_q == LastInitPhase);
      end
      JOB_ONE: begin
        cur_rs   = job_i.rs0;
        cur.last_phase = (phase_q == LastOnePhase);
      end
      JOB_TWO: begin
        cur_rs   = bidx[0] ? job_i.rs1 : job_i.rs0;
        cur_byte = bidx[0] ? job_i.byte1 : job_i.byte0;
        cur.last_phase = (phase_q == LastTwoPhase);
      end
      default: begin
        cur.last_phase = 1'b1;
      end
    endcase

    // even steps strobe a nibble, odd steps are the cleared gap; wait phases never strobe
    cur.reg_select   = cur_rs && !is_wait;
    cur.enable_level = !sub[0] && !is_wait;
    cur.nibble       = '0;
    if (cur.enable_level) begin
      cur.nibble = sub[1] ? (cur_byte[3:0] & NibbleMask) : (cur_byte[7:4] & NibbleMask);
    end
    if (is_wait) begin
      cur.hold_count = (phase_q == 4'd0) ? cfg_i.power_up_wait : cfg_i.clear_wait;
    end else begin
      cur.hold_count = cur.enable_level ? cfg_i.strobe_hold : cfg_i.gap_hold;
    end
  end

  assign advance = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && cur.last_phase;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      phase_d     = cur.last_phase ? 4'd0 : phase_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== tb/sv/char_lcd_nibble_sequencer_tb.sv =====
// self-checking testbench for the character display nibble sequencer
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
  import lcdns_pkg::*;

  localparam int ResetCycles    = 9;
  localparam int SettleCycles   = 40;     // covers ignored commands still in flight
  localparam int HoldOffCycles  = 300;    // long consumer stall for back pressure
  localparam int CycleLimit     = 500000;
  localparam int RandomBatches  = 5;
  localparam int BatchCommands  = 60;
  localparam int PressureCmds   = 24;
  localparam int SteadyCmds     = 40;
  localparam int MaxReported    = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // byte_value[7:0], row[8], column[14:9], zero[15]
  logic [2:0]  s_axis_tuser = '0;   // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // enable_level[0], nibble[4:1], hold_count[20:5], zero
  logic [0:0]  m_axis_tuser;        // reg_select[0]
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  char_lcd_nibble_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow copy of the hold registers
  logic [15:0] strobe_hold_q;
  logic [15:0] gap_hold_q;
  logic [15:0] power_up_wait_q;
  logic [15:0] clear_wait_q;

  phase_t expected_phases[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  bit     idling_on = 1'b1;
  int     hold_off_requests = 0;   // written by the tests only
  int     hold_off_served = 0;     // written by the consumer only
  int     stall_left = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("char_lcd_nibble_sequencer_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // expected phase runs
  // ---------------------------------------------------------------------------

  task automatic push_phase(input logic rs, input logic en, input logic [3:0] nib,
                            input logic [15:0] hold);
    phase_t p;
    p.reg_select   = rs;
    p.enable_level = en;
    p.nibble       = nib;
    p.hold_count   = hold;
    p.last_phase   = 1'b0;
    expected_phases.push_back(p);
  endtask

  // upper nibble first, each nibble a strobe phase then a cleared gap phase
  task automatic push_byte_phases(input logic rs, input logic [7:0] b);
    push_phase(rs, 1'b1, b[7:4], strobe_hold_q);
    push_phase(rs, 1'b0, 4'h0, gap_hold_q);
    push_phase(rs, 1'b1, b[3:0], strobe_hold_q);
    push_phase(rs, 1'b0, 4'h0, gap_hold_q);
  endtask

  task automatic predict_phase_run(input logic [2:0] cmd, input logic [7:0] b,
                                   input logic row, input logic [5:0] col);
    int     before_size;
    phase_t tail;
    before_size = expected_phases.size();
    case (cmd)
      CMD_INIT: begin
        push_phase(1'b0, 1'b0, 4'h0, power_up_wait_q);
        push_byte_phases(1'b0, 8'h2f);   // function set
        push_byte_phases(1'b0, 8'h0c);   // display on
        push_byte_phases(1'b0, 8'h01);   // clear
        push_phase(1'b0, 1'b0, 4'h0, clear_wait_q);
      end
      CMD_INSTR:  push_byte_phases(1'b0, b);
      CMD_DATA:   push_byte_phases(1'b1, b);
      CMD_TEXT: begin
        push_byte_phases(1'b0, EntryModeInstr);
        push_byte_phases(1'b1, b);
      end
      CMD_CURSOR: push_byte_phases(1'b0, SetDdramBase + {1'b0, row, col});
      default: ;  // unused codes give nothing
    endcase
    // tlast goes on the final phase of the run
    if (expected_phases.size() > before_size) begin
      tail = expected_phases.pop_back();
      tail.last_phase = 1'b1;
      expected_phases.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // consumer side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (hold_off_served != hold_off_requests) begin
      m_axis_tready   <= 1'b0;
      stall_left      <= HoldOffCycles - 1;
      hold_off_served <= hold_off_requests;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // phase checker, compares every accepted item with the oldest expectation
  always @(posedge clk_i) begin
    phase_t want;
    phase_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.reg_select   = m_axis_tuser[0];
      got.enable_level = m_axis_tdata[0];
      got.nibble       = m_axis_tdata[4:1];
      got.hold_count   = m_axis_tdata[20:5];
      got.last_phase   = m_axis_tlast;
      if (expected_phases.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MaxReported)
          $display("unexpected phase: rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                   got.reg_select, got.enable_level, got.nibble, got.hold_count,
                   got.last_phase);
      end else begin
        want = expected_phases.pop_front();
        if (got.reg_select !== want.reg_select || got.enable_level !== want.enable_level ||
            got.nibble !== want.nibble || got.hold_count !== want.hold_count ||
            got.last_phase !== want.last_phase) begin
          mismatches = mismatches + 1;
          if (mismatches <= MaxReported) begin
            $write("phase mismatch: expected rs=%0d en=%0d nib=%h hold=%0d last=%0d,",
                   want.reg_select, want.enable_level, want.nibble, want.hold_count,
                   want.last_phase);
            $display(" got rs=%0d en=%0d nib=%h hold=%0d last=%0d",
                     got.reg_select, got.enable_level, got.nibble, got.hold_count,
                     got.last_phase);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // leaves tvalid high after the handshake so back-to-back items need no gap
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] b,
                              input logic row, input logic [5:0] col);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, col, row, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_phase_run(cmd, b, row, col);
  endtask

  task automatic send_random_command(input bit allow_unused, output bit counted);
    logic [2:0] cmd;
    int         pick;
    pick = $urandom_range(0, 99);
    if (allow_unused && pick < 12) cmd = 3'($urandom_range(5, 7));
    else if (pick < 22)            cmd = CMD_INIT;
    else                           cmd = 3'($urandom_range(1, 4));
    send_command(cmd, 8'($urandom), 1'($urandom), 6'($urandom));
    counted = (cmd <= CMD_CURSOR);
  endtask

  // wait for every expected phase, then let ignored commands clear the block
  task automatic drain_phases();
    s_axis_tvalid <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_STROBE_HOLD:   strobe_hold_q   = value;
      REG_GAP_HOLD:      gap_hold_q      = value;
      REG_POWER_UP_WAIT: power_up_wait_q = value;
      REG_CLEAR_WAIT:    clear_wait_q    = value;
      default: ;
    endcase
  endtask

  // only called while the block is idle
  task automatic set_hold_times(input logic [15:0] strobe, input logic [15:0] gap,
                                input logic [15:0] power_up, input logic [15:0] clear);
    write_register(REG_STROBE_HOLD, strobe);
    write_register(REG_GAP_HOLD, gap);
    write_register(REG_POWER_UP_WAIT, power_up);
    write_register(REG_CLEAR_WAIT, clear);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_hold();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset hold values, every command, field extremes, unused codes and fields
  task automatic test_reset_defaults();
    send_command(CMD_INIT, 8'hff, 1'b1, 6'h3f);     // byte and position unused
    send_command(CMD_INSTR, 8'h00, 1'b0, 6'h00);
    send_command(CMD_INSTR, 8'hff, 1'b1, 6'h3f);    // row and column unused
    send_command(CMD_DATA, 8'h00, 1'b1, 6'h2a);
    send_command(CMD_DATA, 8'hff, 1'b0, 6'h15);
    send_command(CMD_TEXT, 8'ha5, 1'b0, 6'h00);
    send_command(CMD_TEXT, 8'h5a, 1'b1, 6'h3f);
    send_command(CMD_CURSOR, 8'hff, 1'b0, 6'h00);   // lowest address
    send_command(CMD_CURSOR, 8'h00, 1'b1, 6'h3f);   // highest address
    send_command(3'd5, 8'h12, 1'b1, 6'h01);         // unused codes are dropped
    send_command(3'd6, 8'hff, 1'b0, 6'h3f);
    send_command(3'd7, 8'h00, 1'b1, 6'h20);
    send_command(CMD_CURSOR, 8'h33, 1'b0, 6'h2a);
    drain_phases();
  endtask

  // all hold registers at zero and at full scale
  task automatic test_register_extremes();
    set_hold_times(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_INIT, 8'h00, 1'b0, 6'h00);
    send_command(CMD_TEXT, 8'h41, 1'b0, 6'h00);
    send_command(CMD_INSTR, 8'h0f, 1'b0, 6'h00);
    drain_phases();
    set_hold_times(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_command(CMD_INIT, 8'h00, 1'b0, 6'h00);
    send_command(CMD_DATA, 8'hc3, 1'b0, 6'h00);
    send_command(CMD_CURSOR, 8'h00, 1'b1, 6'h05);
    drain_phases();
  endtask

  // random commands in batches, new hold values between batches
  task automatic test_random_traffic();
    int sent;
    bit counted;
    for (int batch = 0; batch < RandomBatches; batch++) begin
      set_hold_times(random_hold(), random_hold(), random_hold(), random_hold());
      sent = 0;
      while (sent < BatchCommands) begin
        send_random_command(1'b1, counted);
        if (counted) sent++;
      end
      drain_phases();
    end
  endtask

  // consumer stalls for a long stretch while commands keep coming
  task automatic test_back_pressure();
    bit counted;
    set_hold_times(16'd80, 16'd10, 16'd30000, 16'd65000);
    hold_off_requests = hold_off_requests + 1;
    for (int i = 0; i < PressureCmds; i++) send_random_command(1'b0, counted);
    drain_phases();
  endtask

  // no idling on either side in the last stretch
  task automatic test_steady_stream();
    bit counted;
    idling_on = 1'b0;
    set_hold_times(random_hold(), random_hold(), random_hold(), random_hold());
    for (int i = 0; i < SteadyCmds; i++) send_random_command(1'b1, counted);
    drain_phases();
  endtask

  initial begin
    strobe_hold_q   = StrobeHoldReset;
    gap_hold_q      = GapHoldReset;
    power_up_wait_q = PowerUpWaitReset;
    clear_wait_q    = ClearWaitReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_back_pressure();
    test_steady_stream();

    if (mismatches == 0) begin
      $display("char_lcd_nibble_sequencer_tb: clean");
    end else begin
      $display("char_lcd_nibble_sequencer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lcdns_pkg.sv
design/lcdns_front.sv
design/lcdns_queue.sv
design/lcdns_back.sv
design/char_lcd_nibble_sequencer.sv
tb/sv/char_lcd_nibble_sequencer_tb.sv
